>>> hw/rtl/frtab_pkg.sv
// Shared types and constants for the freed address record table.
// No dependencies; the request and response interfaces and the table module refer to this package by scoped names.
package frtab_pkg;

   localparam int OBJ_CAP   = 4096;
   localparam int OBJ_BITS  = $clog2(OBJ_CAP);
   localparam int REG_CAP   = 1024;
   localparam int REG_BITS  = $clog2(REG_CAP);
   localparam int ADDR_BITS = 48;
   localparam int SIZE_BITS = 32;
   localparam int SEQ_BITS  = 32;
   localparam int WORD_BITS = 64;
   localparam int LIMIT_BITS = 16;
   localparam int PROBES     = 8;
   localparam int PROBE_BITS = $clog2(PROBES);
   localparam int HASH_LO    = 3;
   localparam int HASH_HI    = 21;
   localparam logic [LIMIT_BITS-1:0] MAX_OBJ_RESET = 16'd16384;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      OP_REGION = 2'd0,
      OP_OBJECT = 2'd1,
      OP_JOIN   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_RECORDED = 3'd0,
      KIND_EXACT    = 3'd1,
      KIND_INTERIOR = 3'd2,
      KIND_REGION   = 3'd3,
      KIND_MISS     = 3'd4,
      KIND_IGNORED  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_SCAN,
      ST_RING,
      ST_RESP
   } state_type;

   typedef enum logic {
      CSR_ENABLE = 1'b0,
      CSR_MAX    = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] key;
      logic [SIZE_BITS-1:0] size;
      logic [SEQ_BITS-1:0]  seq;
      logic [WORD_BITS-1:0] word;
   } obj_entry_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] limit;
      logic [SEQ_BITS-1:0]  seq;
      logic [WORD_BITS-1:0] word;
   } ring_entry_type;

   function automatic logic [OBJ_BITS-1:0] home_slot(input logic [ADDR_BITS-1:0] a);
      logic [ADDR_BITS-1:0] h;
      h = (a >> HASH_LO) ^ (a >> HASH_HI);
      return h[OBJ_BITS-1:0];
   endfunction

endpackage

>>> hw/rtl/frtab_req_if.sv
// Request channel of the freed address record table.
// Depends on frtab_pkg for field widths.
interface frtab_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      operation;
   logic [frtab_pkg::ADDR_BITS-1:0] address;
   logic [frtab_pkg::ADDR_BITS-1:0] region_end;
   logic [frtab_pkg::SIZE_BITS-1:0] object_size;
   logic [frtab_pkg::WORD_BITS-1:0] record_word;
   logic                            deep_scan;

   modport source (output valid, operation, address, region_end, object_size,
                   record_word, deep_scan, input ready);
   modport sink   (input valid, operation, address, region_end, object_size,
                   record_word, deep_scan, output ready);
endinterface

>>> hw/rtl/frtab_rsp_if.sv
// Response channel of the freed address record table.
// Depends on frtab_pkg for field widths.
interface frtab_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [2:0]                      result_kind;
   logic [frtab_pkg::ADDR_BITS-1:0] found_base;
   logic [frtab_pkg::ADDR_BITS-1:0] found_limit;
   logic [frtab_pkg::SIZE_BITS-1:0] found_size;
   logic [frtab_pkg::SEQ_BITS-1:0]  found_free_seq;
   logic [frtab_pkg::WORD_BITS-1:0] found_word;
   logic                            evicted;
   logic [31:0]                     regions_total;

   modport source (output valid, result_kind, found_base, found_limit, found_size,
                   found_free_seq, found_word, evicted, regions_total, input ready);
   modport sink   (input valid, result_kind, found_base, found_limit, found_size,
                   found_free_seq, found_word, evicted, regions_total, output ready);
endinterface

>>> hw/rtl/frtab_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frtab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/freed_address_record_table.sv
// Freed address record table: region ring plus linearly probed object hash table.
// After reset a clearing pass over all OBJ_CAP (4096) slots zeroes the object keys; no request
// is taken meanwhile, CSR writes are. Requests are handled one at a time: object insert and
// exact probe visit up to PROBES (8) probe slots, deep scan reads all OBJ_CAP slots, ring
// search reads up to REG_CAP regions, all through the single read port of each table RAM.
// Result is registered; reset is synchronous.
module freed_address_record_table (
   input  logic                                clock,
   input  logic                                reset,
   frtab_req_if.sink                           req_ch,
   frtab_rsp_if.source                         rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [frtab_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [frtab_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [frtab_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);
   localparam int AB = frtab_pkg::ADDR_BITS;
   localparam int OB = frtab_pkg::OBJ_BITS;
   localparam int RB = frtab_pkg::REG_BITS;

   // ---------------- control registers
   frtab_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 enable_ff, enable_in;
   logic [frtab_pkg::LIMIT_BITS-1:0] max_obj_ff, max_obj_in;
   logic [31:0]          region_count_ff, region_count_in;
   logic [frtab_pkg::LIMIT_BITS-1:0] obj_in_region_ff, obj_in_region_in;
   logic [OB:0]          idx_ff, idx_in;          // clear sweep and deep scan index
   logic                 rd_v_ff, rd_v_in;        // a scan read is in flight
   logic [RB:0]          rem_ff, rem_in;          // ring slots still to read

   // ---------------- payload registers
   frtab_pkg::op_type    op_ff, op_in;
   logic [AB-1:0]        addr_ff, addr_in;
   logic [AB-1:0]        rend_ff, rend_in;
   logic [frtab_pkg::SIZE_BITS-1:0] osize_ff, osize_in;
   logic [frtab_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic                 deep_ff, deep_in;
   logic [OB-1:0]        home_ff, home_in;
   logic [frtab_pkg::PROBE_BITS-1:0] probe_ff, probe_in;
   logic [RB-1:0]        rp_ff, rp_in;
   logic                 have_ff, have_in;
   frtab_pkg::obj_entry_type best_ff, best_in;

   // pending result, then the output register
   frtab_pkg::kind_type  res_kind_ff, res_kind_in;
   logic [AB-1:0]        res_base_ff, res_base_in;
   logic [AB-1:0]        res_limit_ff, res_limit_in;
   logic [frtab_pkg::SIZE_BITS-1:0] res_size_ff, res_size_in;
   logic [frtab_pkg::SEQ_BITS-1:0]  res_seq_ff, res_seq_in;
   logic [frtab_pkg::WORD_BITS-1:0] res_word_ff, res_word_in;
   logic                 res_ev_ff, res_ev_in;

   logic [2:0]           out_kind_ff, out_kind_in;
   logic [AB-1:0]        out_base_ff, out_base_in;
   logic [AB-1:0]        out_limit_ff, out_limit_in;
   logic [frtab_pkg::SIZE_BITS-1:0] out_size_ff, out_size_in;
   logic [frtab_pkg::SEQ_BITS-1:0]  out_seq_ff, out_seq_in;
   logic [frtab_pkg::WORD_BITS-1:0] out_word_ff, out_word_in;
   logic                 out_ev_ff, out_ev_in;
   logic [31:0]          out_total_ff, out_total_in;

   // ---------------- RAM ports
   logic                       obj_wr_en;
   logic [OB-1:0]              obj_wr_addr, obj_rd_addr;
   frtab_pkg::obj_entry_type   obj_wr_data, obj_rd_data;
   logic                       ring_wr_en;
   logic [RB-1:0]              ring_wr_addr, ring_rd_addr;
   frtab_pkg::ring_entry_type  ring_wr_data, ring_rd_data;

   frtab_ram #(.WIDTH($bits(frtab_pkg::obj_entry_type)), .DEPTH(frtab_pkg::OBJ_CAP))
      u_obj_ram (
         .clock   (clock),
         .wr_en   (obj_wr_en),
         .wr_addr (obj_wr_addr),
         .wr_data (obj_wr_data),
         .rd_addr (obj_rd_addr),
         .rd_data (obj_rd_data)
      );

   frtab_ram #(.WIDTH($bits(frtab_pkg::ring_entry_type)), .DEPTH(frtab_pkg::REG_CAP))
      u_ring_ram (
         .clock   (clock),
         .wr_en   (ring_wr_en),
         .wr_addr (ring_wr_addr),
         .wr_data (ring_wr_data),
         .rd_addr (ring_rd_addr),
         .rd_data (ring_rd_data)
      );

   // ---------------- CSR port: paddr[2] selects the register, byte offset ignored
   logic                    csr_wr;
   frtab_pkg::csr_reg_type  csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_sel = frtab_pkg::csr_reg_type'(paddr[2]);

   always_comb begin
      unique case (csr_sel)
         frtab_pkg::CSR_ENABLE: prdata = {{(frtab_pkg::CSR_DATA_BITS-1){1'b0}}, enable_ff};
         frtab_pkg::CSR_MAX:    prdata = {{(frtab_pkg::CSR_DATA_BITS-frtab_pkg::LIMIT_BITS){1'b0}},
                                          max_obj_ff};
         default:               prdata = '0;
      endcase
   end

   assign enable_in = (csr_wr && csr_sel == frtab_pkg::CSR_ENABLE) ? pwdata[0] : enable_ff;
   assign max_obj_in = (csr_wr && csr_sel == frtab_pkg::CSR_MAX) ?
                       pwdata[frtab_pkg::LIMIT_BITS-1:0] : max_obj_ff;

   // ---------------- channel ports
   assign req_ch.ready          = (state_ff == frtab_pkg::ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = out_kind_ff;
   assign rsp_ch.found_base     = out_base_ff;
   assign rsp_ch.found_limit    = out_limit_ff;
   assign rsp_ch.found_size     = out_size_ff;
   assign rsp_ch.found_free_seq = out_seq_ff;
   assign rsp_ch.found_word     = out_word_ff;
   assign rsp_ch.evicted        = out_ev_ff;
   assign rsp_ch.regions_total  = out_total_ff;

   // ---------------- compare unit: one covering test per cycle
   logic [AB-1:0] cover_diff;
   logic          obj_covers;
   logic          ring_covers;
   logic [OB-1:0] probe_slot;

   assign cover_diff  = addr_ff - obj_rd_data.key;
   assign obj_covers  = (obj_rd_data.key != '0) && (obj_rd_data.size != '0) &&
                        (addr_ff >= obj_rd_data.key) &&
                        (cover_diff < {{(AB-frtab_pkg::SIZE_BITS){1'b0}}, obj_rd_data.size});
   assign ring_covers = (ring_rd_data.start != '0) &&
                        (ring_rd_data.limit > ring_rd_data.start) &&
                        (addr_ff >= ring_rd_data.start) && (addr_ff < ring_rd_data.limit);
   assign probe_slot  = home_ff + OB'(probe_ff);

   // ---------------- sequencer
   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ch.ready;
      region_count_in  = region_count_ff;
      obj_in_region_in = obj_in_region_ff;
      idx_in           = idx_ff;
      rd_v_in          = 1'b0;
      rem_in           = rem_ff;

      op_in    = op_ff;
      addr_in  = addr_ff;
      rend_in  = rend_ff;
      osize_in = osize_ff;
      word_in  = word_ff;
      deep_in  = deep_ff;
      home_in  = home_ff;
      probe_in = probe_ff;
      rp_in    = rp_ff;
      have_in  = have_ff;
      best_in  = best_ff;

      res_kind_in  = res_kind_ff;
      res_base_in  = res_base_ff;
      res_limit_in = res_limit_ff;
      res_size_in  = res_size_ff;
      res_seq_in   = res_seq_ff;
      res_word_in  = res_word_ff;
      res_ev_in    = res_ev_ff;

      out_kind_in  = out_kind_ff;
      out_base_in  = out_base_ff;
      out_limit_in = out_limit_ff;
      out_size_in  = out_size_ff;
      out_seq_in   = out_seq_ff;
      out_word_in  = out_word_ff;
      out_ev_in    = out_ev_ff;
      out_total_in = out_total_ff;

      obj_wr_en    = 1'b0;
      obj_wr_addr  = probe_slot;
      obj_wr_data  = '{key: addr_ff, size: osize_ff, seq: region_count_ff, word: word_ff};
      obj_rd_addr  = probe_slot;
      ring_wr_en   = 1'b0;
      ring_wr_addr = region_count_ff[RB-1:0];
      ring_wr_data = '{start: addr_ff, limit: rend_ff, seq: region_count_ff + 32'd1,
                       word: word_ff};
      ring_rd_addr = rp_ff;

      unique case (state_ff)
         frtab_pkg::ST_CLEAR: begin
            // zero one key per cycle
            obj_wr_en   = 1'b1;
            obj_wr_addr = idx_ff[OB-1:0];
            obj_wr_data = '0;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff[OB-1:0] == {OB{1'b1}}) begin
               state_in = frtab_pkg::ST_IDLE;
            end
         end

         frtab_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = frtab_pkg::op_type'(req_ch.operation);
               addr_in  = req_ch.address;
               rend_in  = req_ch.region_end;
               osize_in = req_ch.object_size;
               word_in  = req_ch.record_word;
               deep_in  = req_ch.deep_scan;
               state_in = frtab_pkg::ST_DECODE;
            end
         end

         frtab_pkg::ST_DECODE: begin
            res_kind_in  = frtab_pkg::KIND_RECORDED;
            res_base_in  = '0;
            res_limit_in = '0;
            res_size_in  = '0;
            res_seq_in   = '0;
            res_word_in  = '0;
            res_ev_in    = 1'b0;
            home_in      = frtab_pkg::home_slot(addr_ff);
            probe_in     = '0;
            state_in     = frtab_pkg::ST_RESP;
            unique case (op_ff)
               frtab_pkg::OP_REGION: begin
                  if (addr_ff == '0 || rend_ff <= addr_ff) begin
                     res_kind_in = frtab_pkg::KIND_IGNORED;
                  end else begin
                     ring_wr_en       = 1'b1;
                     region_count_in  = region_count_ff + 32'd1;
                     obj_in_region_in = '0;
                  end
               end
               frtab_pkg::OP_OBJECT: begin
                  if (!enable_ff || addr_ff == '0 || obj_in_region_ff >= max_obj_ff) begin
                     res_kind_in = frtab_pkg::KIND_IGNORED;
                  end else begin
                     obj_in_region_in = obj_in_region_ff + 1'b1;
                     state_in         = frtab_pkg::ST_PROBE_RD;
                  end
               end
               frtab_pkg::OP_JOIN: begin
                  if (addr_ff == '0) begin
                     res_kind_in = frtab_pkg::KIND_MISS;
                  end else begin
                     state_in = frtab_pkg::ST_PROBE_RD;
                  end
               end
               default: res_kind_in = frtab_pkg::KIND_IGNORED;
            endcase
         end

         frtab_pkg::ST_PROBE_RD: begin
            // read address is probe_slot by default
            state_in = frtab_pkg::ST_PROBE_CHK;
         end

         frtab_pkg::ST_PROBE_CHK: begin
            if (op_ff == frtab_pkg::OP_OBJECT) begin
               if (obj_rd_data.key == addr_ff || obj_rd_data.key == '0) begin
                  obj_wr_en = 1'b1;
                  state_in  = frtab_pkg::ST_RESP;
               end else if (probe_ff == {frtab_pkg::PROBE_BITS{1'b1}}) begin
                  // no free slot: newest wins at the home slot
                  obj_wr_en   = 1'b1;
                  obj_wr_addr = home_ff;
                  res_ev_in   = 1'b1;
                  state_in    = frtab_pkg::ST_RESP;
               end else begin
                  probe_in = probe_ff + 1'b1;
                  state_in = frtab_pkg::ST_PROBE_RD;
               end
            end else begin
               if (obj_rd_data.key == addr_ff) begin
                  res_kind_in = frtab_pkg::KIND_EXACT;
                  res_base_in = addr_ff;
                  res_size_in = obj_rd_data.size;
                  res_seq_in  = obj_rd_data.seq;
                  res_word_in = obj_rd_data.word;
                  state_in    = frtab_pkg::ST_RESP;
               end else if (obj_rd_data.key == '0 ||
                            probe_ff == {frtab_pkg::PROBE_BITS{1'b1}}) begin
                  idx_in  = '0;
                  have_in = 1'b0;
                  rp_in   = region_count_ff[RB-1:0] - 1'b1;
                  rem_in  = ((region_count_ff >> RB) != 32'd0) ?
                            (RB+1)'(frtab_pkg::REG_CAP) : region_count_ff[RB:0];
                  state_in = deep_ff ? frtab_pkg::ST_SCAN : frtab_pkg::ST_RING;
               end else begin
                  probe_in = probe_ff + 1'b1;
                  state_in = frtab_pkg::ST_PROBE_RD;
               end
            end
         end

         frtab_pkg::ST_SCAN: begin
            // issue one read per cycle, test the entry read the cycle before
            obj_rd_addr = idx_ff[OB-1:0];
            if (!idx_ff[OB]) begin
               idx_in  = idx_ff + 1'b1;
               rd_v_in = 1'b1;
            end
            if (rd_v_ff && obj_covers && (!have_ff || obj_rd_data.seq > best_ff.seq)) begin
               have_in = 1'b1;
               best_in = obj_rd_data;
            end
            if (idx_ff[OB] && !rd_v_ff) begin
               if (have_ff) begin
                  res_kind_in = frtab_pkg::KIND_INTERIOR;
                  res_base_in = best_ff.key;
                  res_size_in = best_ff.size;
                  res_seq_in  = best_ff.seq;
                  res_word_in = best_ff.word;
                  state_in    = frtab_pkg::ST_RESP;
               end else begin
                  state_in = frtab_pkg::ST_RING;
               end
            end
         end

         frtab_pkg::ST_RING: begin
            // newest first; first covering region wins
            if (rem_ff != '0) begin
               rp_in   = rp_ff - 1'b1;
               rem_in  = rem_ff - 1'b1;
               rd_v_in = 1'b1;
            end
            if (rd_v_ff && ring_covers) begin
               res_kind_in  = frtab_pkg::KIND_REGION;
               res_base_in  = ring_rd_data.start;
               res_limit_in = ring_rd_data.limit;
               res_seq_in   = ring_rd_data.seq;
               res_word_in  = ring_rd_data.word;
               rd_v_in      = 1'b0;
               state_in     = frtab_pkg::ST_RESP;
            end else if (rem_ff == '0 && !rd_v_ff) begin
               res_kind_in = frtab_pkg::KIND_MISS;
               state_in    = frtab_pkg::ST_RESP;
            end
         end

         frtab_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_kind_in  = res_kind_ff;
               out_base_in  = res_base_ff;
               out_limit_in = res_limit_ff;
               out_size_in  = res_size_ff;
               out_seq_in   = res_seq_ff;
               out_word_in  = res_word_ff;
               out_ev_in    = res_ev_ff;
               out_total_in = region_count_ff;
               state_in     = frtab_pkg::ST_IDLE;
            end
         end

         default: state_in = frtab_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= frtab_pkg::ST_CLEAR;
         rsp_valid_ff     <= 1'b0;
         enable_ff        <= 1'b1;
         max_obj_ff       <= frtab_pkg::MAX_OBJ_RESET;
         region_count_ff  <= '0;
         obj_in_region_ff <= '0;
         idx_ff           <= '0;
         rd_v_ff          <= 1'b0;
         rem_ff           <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         enable_ff        <= enable_in;
         max_obj_ff       <= max_obj_in;
         region_count_ff  <= region_count_in;
         obj_in_region_ff <= obj_in_region_in;
         idx_ff           <= idx_in;
         rd_v_ff          <= rd_v_in;
         rem_ff           <= rem_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      rend_ff      <= rend_in;
      osize_ff     <= osize_in;
      word_ff      <= word_in;
      deep_ff      <= deep_in;
      home_ff      <= home_in;
      probe_ff     <= probe_in;
      rp_ff        <= rp_in;
      have_ff      <= have_in;
      best_ff      <= best_in;
      res_kind_ff  <= res_kind_in;
      res_base_ff  <= res_base_in;
      res_limit_ff <= res_limit_in;
      res_size_ff  <= res_size_in;
      res_seq_ff   <= res_seq_in;
      res_word_ff  <= res_word_in;
      res_ev_ff    <= res_ev_in;
      out_kind_ff  <= out_kind_in;
      out_base_ff  <= out_base_in;
      out_limit_ff <= out_limit_in;
      out_size_ff  <= out_size_in;
      out_seq_ff   <= out_seq_in;
      out_word_ff  <= out_word_in;
      out_ev_ff    <= out_ev_in;
      out_total_ff <= out_total_in;
   end

endmodule
